>>> hw/rtl/cursor_linked_list_manager_assert.svh
// Assertion macros for the cursor linked list manager checker.
// Needs a clock i_clk and an active low reset i_rst_n in the using scope.
`ifndef CURSOR_LINKED_LIST_MANAGER_ASSERT_SVH
`define CURSOR_LINKED_LIST_MANAGER_ASSERT_SVH

// same-cycle implication
`define CLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/clm_pkg.sv
// Shared types and constants of the cursor linked list manager.
// No dependencies.
`default_nettype none

package clm_pkg;

    localparam int CELLS_DEF = 256;
    localparam int VALUE_W   = 16;
    localparam int IDX_W     = 8;

    localparam logic [VALUE_W-1:0] VAL_RESET = '1;

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_FIND     = 3'd3,
        OP_FINDPREV = 3'd4,
        OP_FREE     = 3'd5,
        OP_READ     = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SPACE    = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic hit;
        logic nul;
        logic last;
    } t_walk_flags;

endpackage

`default_nettype wire

>>> hw/rtl/clm_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none

module clm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/clm_walk.sv
// Shared compare unit for list walks: key match, null link, step limit.
// Depends on clm_pkg.
`default_nettype none

module clm_walk #(
    parameter int CELLS = clm_pkg::CELLS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clr,
    input  wire logic                          i_inc,
    input  wire logic [clm_pkg::VALUE_W-1:0]   i_key,
    input  wire logic [clm_pkg::VALUE_W-1:0]   i_value,
    input  wire logic [$clog2(CELLS)-1:0]      i_link,
    output clm_pkg::t_walk_flags               o_flags
);
    import clm_pkg::*;

    localparam int IW = $clog2(CELLS);

    logic [IW-1:0] r_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (i_clr) begin
            r_steps <= '0;
        end else if (i_inc) begin
            r_steps <= r_steps + 1'b1;
        end
    end

    assign o_flags.hit  = (i_value == i_key);
    assign o_flags.nul  = (i_link == '0);
    assign o_flags.last = (r_steps == IW'(CELLS - 1));

endmodule

`default_nettype wire

>>> hw/rtl/cursor_linked_list_manager.sv
// Top level of the cursor linked list manager: sequencer, link and value RAMs.
// Depends on clm_pkg, clm_ram, clm_walk.
//
//  channel  | handshake            | words
//  ---------+----------------------+---------------------------------------------
//  command  | start && !busy       | operation, value, list_head, position
//  result   | o_done (one cycle)   | result_cell, cell_value, cell_next, status
//
// Refused or unused commands answer straight from idle; read, create, insert,
// find / find previous, delete and free step through their own states, and a
// walk reads the link RAM once per cell that it visits.
// After reset a clearing pass writes every cell, busy high.
// The result strobe cannot be stalled; a new command may start while it shows.
`default_nettype none

module cursor_linked_list_manager #(
    parameter int CELLS = clm_pkg::CELLS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [2:0]                         i_operation,
    input  wire logic signed [clm_pkg::VALUE_W-1:0] i_value,
    input  wire logic [clm_pkg::IDX_W-1:0]          i_list_head,
    input  wire logic [clm_pkg::IDX_W-1:0]          i_position,
    output logic                                    o_done,
    output logic [clm_pkg::IDX_W-1:0]               o_result_cell,
    output logic signed [clm_pkg::VALUE_W-1:0]      o_cell_value,
    output logic [clm_pkg::IDX_W-1:0]               o_cell_next,
    output logic [1:0]                              o_status
);
    import clm_pkg::*;

    localparam int IW = $clog2(CELLS);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_TK0, S_TK1, S_CLR, S_INS, S_INS2,
        S_WLINK, S_WCMP, S_DEL1, S_DEL2,
        S_F1, S_F2, S_FRD, S_FWR, S_FEND, S_READ
    } t_state;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [VALUE_W-1:0]   r_v, n_v;
    logic [IW-1:0]        r_head, n_head;
    logic [IW-1:0]        r_pos, n_pos;
    logic [IW-1:0]        r_p, n_p;
    logic [IW-1:0]        r_n, n_n;
    logic [IW-1:0]        r_c, n_c;
    logic [IW-1:0]        r_f0, n_f0;
    logic [IW-1:0]        r_res, n_res;
    logic [VALUE_W-1:0]   r_cval, n_cval;
    logic [IW-1:0]        r_cnext, n_cnext;
    t_status              r_status, n_status;
    logic                 r_done, n_done;

    logic [IW-1:0]        raddr;
    logic                 lwe;
    logic [IW-1:0]        lwaddr;
    logic [IW-1:0]        lwdata;
    logic                 vwe;
    logic [IW-1:0]        vwaddr;
    logic [VALUE_W-1:0]   vwdata;
    logic [IW-1:0]        link_rd;
    logic [VALUE_W-1:0]   val_rd;
    logic                 walk_clr;
    logic                 walk_inc;
    t_walk_flags          wf;

    logic                 head_bad;
    logic                 pos_oor;

    clm_ram #(.WIDTH(IW), .DEPTH(CELLS)) u_links (
        .i_clk   (i_clk),
        .i_we    (lwe),
        .i_waddr (lwaddr),
        .i_wdata (lwdata),
        .i_raddr (raddr),
        .o_rdata (link_rd)
    );

    clm_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_values (
        .i_clk   (i_clk),
        .i_we    (vwe),
        .i_waddr (vwaddr),
        .i_wdata (vwdata),
        .i_raddr (raddr),
        .o_rdata (val_rd)
    );

    clm_walk #(.CELLS(CELLS)) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (walk_clr),
        .i_inc   (walk_inc),
        .i_key   (r_v),
        .i_value (val_rd),
        .i_link  (link_rd),
        .o_flags (wf)
    );

    assign pos_oor  = (32'(i_position) >= CELLS);
    assign head_bad = (i_list_head == '0) || (32'(i_list_head) >= CELLS);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_v      = r_v;
        n_head   = r_head;
        n_pos    = r_pos;
        n_p      = r_p;
        n_n      = r_n;
        n_c      = r_c;
        n_f0     = r_f0;
        n_res    = r_res;
        n_cval   = r_cval;
        n_cnext  = r_cnext;
        n_status = r_status;
        n_done   = 1'b0;
        raddr    = '0;
        lwe      = 1'b0;
        lwaddr   = '0;
        lwdata   = '0;
        vwe      = 1'b0;
        vwaddr   = '0;
        vwdata   = '0;
        walk_clr = 1'b0;
        walk_inc = 1'b0;

        case (r_state)
            S_INIT: begin
                lwe    = 1'b1;
                lwaddr = r_p;
                lwdata = (r_p == IW'(CELLS - 1)) ? '0 : r_p + 1'b1;
                vwe    = 1'b1;
                vwaddr = r_p;
                vwdata = VAL_RESET;
                if (r_p == IW'(CELLS - 1)) begin
                    n_p     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op     = t_op'(i_operation);
                    n_v      = i_value;
                    n_head   = IW'(i_list_head);
                    n_pos    = IW'(i_position);
                    n_res    = '0;
                    n_cval   = '0;
                    n_cnext  = '0;
                    n_status = ST_OK;
                    walk_clr = 1'b1;
                    case (t_op'(i_operation))
                        OP_CREATE: begin
                            n_state = S_TK0;
                        end
                        OP_INSERT: begin
                            if (i_position == '0 || pos_oor) begin
                                n_status = ST_NOTFOUND;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_TK0;
                            end
                        end
                        OP_DELETE, OP_FIND, OP_FINDPREV: begin
                            if (head_bad) begin
                                n_status = ST_NOTFOUND;
                                n_done   = 1'b1;
                            end else begin
                                raddr   = IW'(i_list_head);
                                n_state = S_WLINK;
                            end
                        end
                        OP_FREE: begin
                            if (head_bad) begin
                                n_status = ST_NOTFOUND;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_F1;
                            end
                        end
                        OP_READ: begin
                            if (pos_oor) begin
                                n_status = ST_NOTFOUND;
                                n_done   = 1'b1;
                            end else begin
                                raddr   = IW'(i_position);
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_TK0: begin
                if (link_rd == '0) begin
                    n_status = ST_SPACE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_c     = link_rd;
                    raddr   = link_rd;
                    n_state = S_TK1;
                end
            end
            S_TK1: begin
                lwe    = 1'b1;
                lwaddr = '0;
                lwdata = link_rd;
                vwe    = 1'b1;
                vwaddr = r_c;
                vwdata = (r_op == OP_CREATE) ? VAL_RESET : r_v;
                if (r_op == OP_CREATE) begin
                    n_state = S_CLR;
                end else begin
                    raddr   = r_pos;
                    n_state = S_INS;
                end
            end
            S_CLR: begin
                lwe     = 1'b1;
                lwaddr  = r_c;
                lwdata  = '0;
                n_res   = r_c;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_INS: begin
                lwe     = 1'b1;
                lwaddr  = r_c;
                lwdata  = link_rd;
                n_state = S_INS2;
            end
            S_INS2: begin
                lwe     = 1'b1;
                lwaddr  = r_pos;
                lwdata  = r_c;
                n_res   = r_c;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_WLINK: begin
                if (wf.nul) begin
                    n_status = ST_NOTFOUND;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_p     = r_head;
                    n_n     = link_rd;
                    raddr   = link_rd;
                    n_state = S_WCMP;
                end
            end
            S_WCMP: begin
                if (wf.hit) begin
                    case (r_op)
                        OP_FIND: begin
                            n_res   = r_n;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                        OP_FINDPREV: begin
                            n_res   = r_p;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                        default: begin
                            lwe     = 1'b1;
                            lwaddr  = r_p;
                            lwdata  = link_rd;
                            n_state = S_DEL1;
                        end
                    endcase
                end else if (wf.last || wf.nul) begin
                    n_status = ST_NOTFOUND;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_p      = r_n;
                    n_n      = link_rd;
                    raddr    = link_rd;
                    walk_inc = 1'b1;
                end
            end
            S_DEL1: begin
                lwe     = 1'b1;
                lwaddr  = r_n;
                lwdata  = link_rd;
                n_state = S_DEL2;
            end
            S_DEL2: begin
                lwe     = 1'b1;
                lwaddr  = '0;
                lwdata  = r_n;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_F1: begin
                n_f0    = link_rd;
                raddr   = r_head;
                n_state = S_F2;
            end
            S_F2: begin
                lwe    = 1'b1;
                lwaddr = r_head;
                lwdata = '0;
                if (link_rd == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_p     = link_rd;
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                raddr   = r_p;
                n_state = S_FWR;
            end
            S_FWR: begin
                lwe    = 1'b1;
                lwaddr = r_p;
                lwdata = r_f0;
                n_f0   = r_p;
                if (wf.nul || wf.last) begin
                    n_state = S_FEND;
                end else begin
                    n_p      = link_rd;
                    walk_inc = 1'b1;
                    n_state  = S_FRD;
                end
            end
            S_FEND: begin
                lwe     = 1'b1;
                lwaddr  = '0;
                lwdata  = r_f0;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_READ: begin
                n_res   = r_pos;
                n_cval  = val_rd;
                n_cnext = link_rd;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_p     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_v      <= n_v;
            r_head   <= n_head;
            r_pos    <= n_pos;
            r_p      <= n_p;
            r_n      <= n_n;
            r_c      <= n_c;
            r_f0     <= n_f0;
            r_res    <= n_res;
            r_cval   <= n_cval;
            r_cnext  <= n_cnext;
            r_status <= n_status;
            r_done   <= n_done;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_result_cell = IDX_W'(r_res);
    assign o_cell_value  = r_cval;
    assign o_cell_next   = IDX_W'(r_cnext);
    assign o_status      = r_status;

endmodule

`default_nettype wire

>>> hw/rtl/clm_checker.sv
// Port-level checks of the cursor linked list manager, bound to the top level.
// Depends on clm_pkg and cursor_linked_list_manager_assert.svh.
`default_nettype none

`include "cursor_linked_list_manager_assert.svh"

module clm_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          o_done,
    input  wire logic [clm_pkg::IDX_W-1:0]     o_result_cell,
    input  wire logic [clm_pkg::VALUE_W-1:0]   o_cell_value,
    input  wire logic [clm_pkg::IDX_W-1:0]     o_cell_next,
    input  wire logic [1:0]                    o_status
);
    import clm_pkg::*;

    // every accepted word either finishes at once or holds busy
    `CLM_ASSERT_NEXT(a_accept_progress, start && !busy, o_done || busy, "command lost")

    // a result only shows once the sequencer is back to idle
    `CLM_ASSERT_NOW(a_done_idle, o_done, !busy, "result while busy")

    // failed commands report no cell and no data
    `CLM_ASSERT_NOW(a_fail_empty, o_done && (o_status == ST_SPACE || o_status == ST_NOTFOUND), o_result_cell == '0 && o_cell_value == '0 && o_cell_next == '0, "failure with data")

    // status code in range
    `CLM_ASSERT_NOW(a_status_legal, o_done, o_status != 2'd3, "bad status")

endmodule

bind cursor_linked_list_manager clm_checker u_clm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_result_cell (o_result_cell),
    .o_cell_value  (o_cell_value),
    .o_cell_next   (o_cell_next),
    .o_status      (o_status)
);

`default_nettype wire

>>> tb/tb_cursor_linked_list_manager.sv
// Self-checking testbench for cursor_linked_list_manager: directed and random commands
// are checked against an in-bench model of the cell store and free list.
// Depends on clm_pkg and the cursor_linked_list_manager RTL.
`timescale 1ns / 100ps

module tb_cursor_linked_list_manager;
    import clm_pkg::*;

    localparam int N_CELLS    = CELLS_DEF;
    localparam int ITEMS      = 1300;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAX_SHOWN  = 10;
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]                op;
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          head;
        logic [IDX_W-1:0]          pos;
    } t_list_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]          res_cell;
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          nxt;
        logic [1:0]                status;
    } t_list_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [2:0]                i_operation = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic [IDX_W-1:0]          i_list_head = '0;
    logic [IDX_W-1:0]          i_position = '0;
    logic                      o_done;
    logic [IDX_W-1:0]          o_result_cell;
    logic signed [VALUE_W-1:0] o_cell_value;
    logic [IDX_W-1:0]          o_cell_next;
    logic [1:0]                o_status;

    logic [IDX_W-1:0]   link_mem [N_CELLS];
    logic [VALUE_W-1:0] val_mem  [N_CELLS];
    logic [IDX_W-1:0]   live_heads [$];
    logic signed [VALUE_W-1:0] value_pool [8];

    t_list_cmd  pending_cmds [$];
    t_list_word pending_results [$];

    int   fault_cnt = 0;
    int   idle_cycles = 0;
    int   sent = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    logic took_word = 1'b0;

    cursor_linked_list_manager #(.CELLS(N_CELLS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_list_head   (i_list_head),
        .i_position    (i_position),
        .o_done        (o_done),
        .o_result_cell (o_result_cell),
        .o_cell_value  (o_cell_value),
        .o_cell_next   (o_cell_next),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic note_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= MAX_SHOWN) $display("%s", msg);
    endtask

    // ---- store model ----
    function automatic logic [IDX_W-1:0] pop_free_cell();
        logic [IDX_W-1:0] c;
        c = link_mem[0];
        if (c != 0) link_mem[0] = link_mem[c];
        return c;
    endfunction

    function automatic void recycle_cell(input logic [IDX_W-1:0] c);
        link_mem[c] = link_mem[0];
        link_mem[0] = c;
    endfunction

    // cell whose successor holds v; walk capped at N_CELLS steps
    function automatic logic [IDX_W-1:0] cell_before(input logic [VALUE_W-1:0] v,
                                                     input logic [IDX_W-1:0] head);
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] n;
        p = head;
        for (int s = 0; s < N_CELLS; s++) begin
            n = link_mem[p];
            if (n == 0) return '0;
            if (val_mem[n] == v) return p;
            p = n;
        end
        return '0;
    endfunction

    task automatic step_list_store(input t_list_cmd c, output t_list_word r);
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] t;
        int s;
        r = '0;
        r.status = ST_OK;
        case (c.op)
            OP_CREATE: begin
                t = pop_free_cell();
                if (t == 0) begin
                    r.status = ST_SPACE;
                end else begin
                    val_mem[t]  = VAL_RESET;
                    link_mem[t] = '0;
                    r.res_cell = t;
                    live_heads.push_back(t);
                end
            end
            OP_INSERT: begin
                if (c.pos == 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    t = pop_free_cell();
                    if (t == 0) begin
                        r.status = ST_SPACE;
                    end else begin
                        val_mem[t]      = c.value;
                        link_mem[t]     = link_mem[c.pos];
                        link_mem[c.pos] = t;
                        r.res_cell = t;
                    end
                end
            end
            OP_DELETE, OP_FIND, OP_FINDPREV: begin
                p = (c.head == 0) ? '0 : cell_before(c.value, c.head);
                if (p == 0) begin
                    r.status = ST_NOTFOUND;
                end else if (c.op == OP_FINDPREV) begin
                    r.res_cell = p;
                end else if (c.op == OP_FIND) begin
                    r.res_cell = link_mem[p];
                end else begin
                    t = link_mem[p];
                    link_mem[p] = link_mem[t];
                    recycle_cell(t);
                end
            end
            OP_FREE: begin
                if (c.head == 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    p = link_mem[c.head];
                    link_mem[c.head] = '0;
                    for (s = 0; s < N_CELLS && p != 0; s++) begin
                        t = link_mem[p];
                        recycle_cell(p);
                        p = t;
                    end
                    for (s = live_heads.size() - 1; s >= 0; s--)
                        if (live_heads[s] == c.head) live_heads.delete(s);
                end
            end
            OP_READ: begin
                r.res_cell = c.pos;
                r.value    = val_mem[c.pos];
                r.nxt      = link_mem[c.pos];
            end
            default: ;
        endcase
    endtask

    // ---- stimulus helpers ----
    function automatic t_list_cmd mk(input logic [2:0] op, input int v,
                                     input int head, input int pos);
        t_list_cmd c;
        c.op    = op;
        c.value = VALUE_W'(v);
        c.head  = IDX_W'(head);
        c.pos   = IDX_W'(pos);
        return c;
    endfunction

    function automatic logic [IDX_W-1:0] cell_in_list(input logic [IDX_W-1:0] head);
        logic [IDX_W-1:0] p;
        int k;
        p = head;
        k = $urandom_range(0, 6);
        for (int i = 0; i < k && link_mem[p] != 0; i++) p = link_mem[p];
        return p;
    endfunction

    function automatic t_list_cmd rand_cmd(input int mode);
        t_list_cmd c;
        logic [IDX_W-1:0] h;
        int r;
        int wc;
        int wi;
        int wd;
        int wf;
        int wr;
        c.op    = 3'($urandom_range(0, 7));
        c.value = VALUE_W'($urandom);
        c.head  = IDX_W'($urandom);
        c.pos   = IDX_W'($urandom);
        if ($urandom_range(0, 11) == 0) return c;
        if (live_heads.size() != 0) h = live_heads[$urandom_range(0, live_heads.size() - 1)];
        else h = IDX_W'($urandom_range(1, N_CELLS - 1));
        if ($urandom_range(0, 4) != 0) c.value = value_pool[$urandom_range(0, 7)];
        c.head = h;
        c.pos  = cell_in_list(h);
        case (mode)
            MODE_GROW: begin
                wc = 12; wi = 50; wd = 5; wf = 15; wr = 2;
            end
            MODE_SHRINK: begin
                wc = 3; wi = 12; wd = 35; wf = 18; wr = 20;
            end
            default: begin
                wc = 8; wi = 30; wd = 17; wf = 20; wr = 7;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < wc) c.op = OP_CREATE;
        else if (r < wc + wi) c.op = OP_INSERT;
        else if (r < wc + wi + wd) c.op = OP_DELETE;
        else if (r < wc + wi + wd + wf) c.op = $urandom_range(0, 1) ? OP_FIND : OP_FINDPREV;
        else if (r < wc + wi + wd + wf + wr) c.op = OP_FREE;
        else c.op = OP_READ;
        if (live_heads.size() == 0 && $urandom_range(0, 1) == 1) c.op = OP_CREATE;
        return c;
    endfunction

    task automatic queue_cmd(input t_list_cmd c);
        pending_cmds.push_back(c);
        sent++;
    endtask

    task automatic next_slot();
        @(posedge i_clk);
        #1;
    endtask

    // hold off until every command has been taken and answered
    task automatic settle();
        while (pending_cmds.size() != 0 || start || pending_results.size() != 0) next_slot();
    endtask

    // ---- driver ----
    always @(negedge i_clk) begin : drive
        t_list_cmd c;
        if (i_rst_n && (!start || took_word)) begin
            if (gap_left > 0 || pending_cmds.size() == 0) begin
                if (gap_left > 0) gap_left--;
                start <= 1'b0;
            end else begin
                c = pending_cmds.pop_front();
                i_operation <= c.op;
                i_value     <= c.value;
                i_list_head <= c.head;
                i_position  <= c.pos;
                start       <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(0, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin : watch
        t_list_word want;
        t_list_word got;
        if (!i_rst_n) begin
            took_word   <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (o_done) begin
                got.res_cell = o_result_cell;
                got.value    = o_cell_value;
                got.nxt      = o_cell_next;
                got.status   = o_status;
                if (pending_results.size() == 0) begin
                    note_fault($sformatf(
                        "%0t: unexpected word cell=%0d value=%0d next=%0d status=%0d",
                        $time, got.res_cell, got.value, got.nxt, got.status));
                end else begin
                    want = pending_results.pop_front();
                    if (got.res_cell !== want.res_cell || got.value !== want.value ||
                        got.nxt !== want.nxt || got.status !== want.status)
                        note_fault($sformatf(
                            {"%0t: expected cell=%0d value=%0d next=%0d status=%0d,",
                             " got cell=%0d value=%0d next=%0d status=%0d"}, $time,
                            want.res_cell, want.value, want.nxt, want.status,
                            got.res_cell, got.value, got.nxt, got.status));
                end
            end
            if (start && !busy) begin
                step_list_store(mk(i_operation, i_value, i_list_head, i_position), want);
                pending_results.push_back(want);
            end
            took_word   <= start && !busy;
            idle_cycles <= (o_done || (start && !busy)) ? 0 : idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("cursor_linked_list_manager verification failed");
            $finish;
        end
    end

    // ---- stimulus ----
    initial begin : stimulus
        int i;
        int n;
        int mode;
        int free_cnt;
        bit filled;
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] h;
        filled = 1'b0;
        for (i = 0; i < N_CELLS; i++) begin
            val_mem[i]  = VAL_RESET;
            link_mem[i] = IDX_W'((i + 1) % N_CELLS);
        end
        value_pool[0] = VALUE_W'(-32768);
        value_pool[1] = VALUE_W'(32767);
        value_pool[2] = '0;
        value_pool[3] = '1;
        for (i = 4; i < 8; i++) value_pool[i] = VALUE_W'($urandom);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        queue_cmd(mk(OP_READ, 0, 0, 0));
        queue_cmd(mk(OP_READ, 0, 0, N_CELLS - 1));
        queue_cmd(mk(OP_CREATE, 0, 77, 200));
        queue_cmd(mk(OP_INSERT, 32767, 0, 1));
        queue_cmd(mk(OP_INSERT, -32768, 9, 2));
        queue_cmd(mk(OP_INSERT, 0, 0, 1));
        queue_cmd(mk(OP_FIND, -32768, 1, 0));
        queue_cmd(mk(OP_FINDPREV, -32768, 1, 0));
        queue_cmd(mk(OP_FIND, 12345, 1, 0));
        queue_cmd(mk(OP_DELETE, 32767, 1, 0));
        queue_cmd(mk(OP_DELETE, 32767, 1, 0));
        queue_cmd(mk(OP_READ, 0, 0, 1));
        queue_cmd(mk(OP_INSERT, 5, 1, 0));
        queue_cmd(mk(OP_FIND, -1, 0, 0));
        queue_cmd(mk(OP_DELETE, -1, 0, 0));
        queue_cmd(mk(OP_FINDPREV, -1, 0, 0));
        queue_cmd(mk(OP_FREE, 0, 0, 0));
        queue_cmd(mk(OP_UNUSED, -1, 255, 255));
        // insert onto the free-list head: the new cell links to itself
        queue_cmd(mk(OP_INSERT, 7, 0, 2));
        queue_cmd(mk(OP_FIND, 99, 2, 0));
        queue_cmd(mk(OP_DELETE, 99, 2, 0));
        queue_cmd(mk(OP_FREE, 0, 2, 0));
        queue_cmd(mk(OP_FREE, 0, 1, 0));
        queue_cmd(mk(OP_READ, 0, 0, 0));
        settle();

        while (sent < ITEMS) begin
            if (!filled && sent >= ITEMS / 2) begin
                // exhaust the free list, then release everything
                filled = 1'b1;
                settle();
                queue_cmd(mk(OP_CREATE, 0, 0, 0));
                settle();
                free_cnt = 0;
                p = link_mem[0];
                while (p != 0 && free_cnt < N_CELLS) begin
                    free_cnt++;
                    p = link_mem[p];
                end
                for (i = 0; i < free_cnt + 3; i++) begin
                    if (live_heads.size() == 0 || $urandom_range(0, 9) == 0) begin
                        queue_cmd(mk(OP_CREATE, 0, $urandom, $urandom));
                    end else begin
                        h = live_heads[$urandom_range(0, live_heads.size() - 1)];
                        queue_cmd(mk(OP_INSERT, $urandom, 0, cell_in_list(h)));
                    end
                end
                settle();
                foreach (live_heads[k]) queue_cmd(mk(OP_FREE, 0, live_heads[k], 0));
                settle();
            end
            while (pending_cmds.size() > 4) next_slot();
            if ($urandom_range(0, 5) == 0) settle();
            if ($urandom_range(0, 7) == 0) value_pool[$urandom_range(4, 7)] = VALUE_W'($urandom);
            mode = $urandom_range(MODE_GROW, MODE_MIX);
            n = $urandom_range(8, 24);
            for (i = 0; i < n; i++) queue_cmd(rand_cmd(mode));
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_fault($sformatf("%0d words never arrived", pending_results.size()));
        if (fault_cnt == 0)
            $display("cursor_linked_list_manager verification clean");
        else
            $display("cursor_linked_list_manager verification failed");
        $finish;
    end

endmodule

>>> cursor_linked_list_manager.f
+incdir+hw/rtl
hw/rtl/clm_pkg.sv
hw/rtl/clm_ram.sv
hw/rtl/clm_walk.sv
hw/rtl/cursor_linked_list_manager.sv
hw/rtl/clm_checker.sv
tb/tb_cursor_linked_list_manager.sv
